FILE: rtl/sha1md_pkg.sv
// ----------------------------------------------------------------------------
// sha1md_pkg
// Shared types and constants of the SHA-1 message digest block.
// ----------------------------------------------------------------------------
`default_nettype none

package sha1md_pkg;

  typedef logic [31:0] word_t;

  // One classified input transaction as it travels from front to back.
  typedef struct packed {
    logic [7:0] data_byte;
    logic       has_byte;
    logic       end_of_message;
  } cmd_t;

  // Back-end sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAD,
    ST_LEN,
    ST_ROUND,
    ST_FOLD,
    ST_OUT
  } state_t;

  localparam int QUEUE_DEPTH_DEF = 4;

  localparam int    DIGEST_WORDS = 5;
  localparam word_t H_INIT [DIGEST_WORDS] = '{
    32'h67452301, 32'hefcdab89, 32'h98badcfe, 32'h10325476, 32'hc3d2e1f0
  };

  localparam word_t K_0 = 32'h5a827999;
  localparam word_t K_1 = 32'h6ed9eba1;
  localparam word_t K_2 = 32'h8f1bbcdc;
  localparam word_t K_3 = 32'hca62c1d6;

  localparam logic [7:0] PAD_MARK = 8'h80;

  localparam logic [6:0] LAST_ROUND  = 7'd79;
  localparam logic [5:0] LEN_OFFSET  = 6'd56;
  localparam logic [5:0] BLOCK_LAST  = 6'd63;
  localparam logic [2:0] LAST_INDEX  = 3'd4;

endpackage

`default_nettype wire

FILE: rtl/sha1_message_digest.sv
// ----------------------------------------------------------------------------
// sha1_message_digest
// SHA-1 over a byte stream, one byte per input transaction.
// ----------------------------------------------------------------------------
// Usage: each input transaction carries one message byte (in_has_byte) and
// an end mark (in_end_of_message); a transaction with neither is dropped.
// The end mark closes the message: padding and the bit length are added and
// five output transactions follow, digest word 0 first, out_last_word on 4.
// A front register and a command queue take input while the back end works.
// The back end packs bytes into the schedule window and, once a 64-byte
// block is full, runs its 80 rounds on one round unit and then folds the
// result into the chaining state; it pops no bytes from the queue meanwhile.
// Closing a message adds the pad mark and zero bytes (up to 64 pad bytes),
// the two length words and, where needed, an extra block, then the digest.
// When the receiver stalls, the current digest word holds and the queue
// fills; then in_ready falls. Synchronous reset restores the initial
// chaining values and clears all counters; no clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module sha1_message_digest
  import sha1md_pkg::*;
#(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         in_valid,
  output logic        in_ready,
  input  wire  [7:0]  in_data_byte,
  input  wire         in_has_byte,
  input  wire         in_end_of_message,
  output logic        out_valid,
  input  wire         out_ready,
  output logic [31:0] out_digest_word,
  output logic [2:0]  out_word_index,
  output logic        out_last_word
);

  logic push;
  cmd_t push_cmd;
  logic full;
  logic pop;
  cmd_t head_cmd;
  logic empty;

  sha1md_front u_front (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_data_byte      (in_data_byte),
    .in_has_byte       (in_has_byte),
    .in_end_of_message (in_end_of_message),
    .push              (push),
    .push_cmd          (push_cmd),
    .full              (full)
  );

  sha1md_queue #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .full     (full),
    .pop      (pop),
    .head_cmd (head_cmd),
    .empty    (empty)
  );

  sha1md_core u_core (
    .clk             (clk),
    .rst_n           (rst_n),
    .head_cmd        (head_cmd),
    .empty           (empty),
    .pop             (pop),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_digest_word (out_digest_word),
    .out_word_index  (out_word_index),
    .out_last_word   (out_last_word)
  );

endmodule

`default_nettype wire

FILE: rtl/sha1md_queue.sv
// ----------------------------------------------------------------------------
// sha1md_queue
// Short first-in first-out queue of commands between front and back.
// ----------------------------------------------------------------------------
`default_nettype none

module sha1md_queue
  import sha1md_pkg::*;
#(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  wire  clk,
  input  wire  rst_n,
  input  wire  push,
  input  cmd_t push_cmd,
  output logic full,
  input  wire  pop,
  output cmd_t head_cmd,
  output logic empty
);

  localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

  cmd_t          slot_r [QUEUE_DEPTH];
  logic [AW-1:0] wr_ptr_r;
  logic [AW-1:0] rd_ptr_r;
  logic [AW:0]   count_r;

  assign full     = (count_r == (AW+1)'(QUEUE_DEPTH));
  assign empty    = (count_r == '0);
  assign head_cmd = slot_r[rd_ptr_r];

  // Storage is written at the tail only.
  always_ff @(posedge clk) begin
    if (push && !full) begin
      slot_r[wr_ptr_r] <= push_cmd;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push && !full) begin
        wr_ptr_r <= (wr_ptr_r == AW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop && !empty) begin
        rd_ptr_r <= (rd_ptr_r == AW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      case ({push && !full, pop && !empty})
        2'b10:   count_r <= count_r + 1'b1;
        2'b01:   count_r <= count_r - 1'b1;
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: rtl/sha1md_front.sv
// ----------------------------------------------------------------------------
// sha1md_front
// Input stage: registers transactions, drops empty ones, feeds the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module sha1md_front
  import sha1md_pkg::*;
(
  input  wire        clk,
  input  wire        rst_n,
  input  wire        in_valid,
  output logic       in_ready,
  input  wire  [7:0] in_data_byte,
  input  wire        in_has_byte,
  input  wire        in_end_of_message,
  output logic       push,
  output cmd_t       push_cmd,
  input  wire        full
);

  logic hold_valid_r;
  cmd_t hold_r;
  logic accept;
  logic useful;

  // The stage takes a transaction when empty or when it drains this cycle.
  assign in_ready = !hold_valid_r || !full;
  assign accept   = in_valid && in_ready;
  // A transaction with neither byte nor end mark has no effect.
  assign useful   = in_has_byte || in_end_of_message;
  assign push     = hold_valid_r && !full;
  assign push_cmd = hold_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_valid_r <= 1'b0;
    end else if (accept && useful) begin
      hold_valid_r <= 1'b1;
    end else if (push) begin
      hold_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && useful) begin
      hold_r.data_byte      <= in_data_byte;
      hold_r.has_byte       <= in_has_byte;
      hold_r.end_of_message <= in_end_of_message;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/sha1md_core.sv
// ----------------------------------------------------------------------------
// sha1md_core
// Back end: packs bytes, pads, runs 80 rounds per block, emits the digest.
// ----------------------------------------------------------------------------
`default_nettype none

module sha1md_core
  import sha1md_pkg::*;
(
  input  wire         clk,
  input  wire         rst_n,
  input  cmd_t        head_cmd,
  input  wire         empty,
  output logic        pop,
  output logic        out_valid,
  input  wire         out_ready,
  output logic [31:0] out_digest_word,
  output logic [2:0]  out_word_index,
  output logic        out_last_word
);

  state_t state_r, state_nxt;

  word_t        chain_r [DIGEST_WORDS];
  word_t        w_r [16];
  word_t        a_r, b_r, c_r, d_r, e_r;
  logic [6:0]   rnd_r;
  logic [5:0]   bib_r;
  logic [23:0]  acc_r;
  logic [60:0]  msg_bytes_r;
  logic         padding_r;
  logic         pad_first_r;
  logic         len_sel_r;
  logic         final_r;
  logic [2:0]   idx_r;

  logic         put_en;
  logic [7:0]   put_val;
  logic         count_en;
  logic         len_push;
  logic         round_en;
  logic         fold_en;
  logic         start_comp;
  logic         shift_en;
  word_t        shift_in;
  word_t        w_new;
  word_t        wt;
  word_t        f_val;
  word_t        k_val;
  word_t        tmp;
  word_t        len_word;
  logic [63:0]  bit_len;
  logic         out_done;

  // Next-state logic.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (!empty) begin
          if (head_cmd.has_byte && bib_r == BLOCK_LAST) begin
            state_nxt = ST_ROUND;
          end else if (head_cmd.end_of_message) begin
            state_nxt = ST_PAD;
          end
        end
      end
      ST_PAD: begin
        if (pad_first_r || bib_r != LEN_OFFSET) begin
          if (bib_r == BLOCK_LAST) begin
            state_nxt = ST_ROUND;
          end
        end else begin
          state_nxt = ST_LEN;
        end
      end
      ST_LEN: begin
        if (len_sel_r) begin
          state_nxt = ST_ROUND;
        end
      end
      ST_ROUND: begin
        if (rnd_r == LAST_ROUND) begin
          state_nxt = ST_FOLD;
        end
      end
      ST_FOLD: begin
        if (final_r) begin
          state_nxt = ST_OUT;
        end else if (padding_r) begin
          state_nxt = ST_PAD;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_OUT: begin
        if (out_ready && idx_r == LAST_INDEX) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Output and control decode per state.
  always_comb begin
    pop       = 1'b0;
    put_en    = 1'b0;
    put_val   = head_cmd.data_byte;
    count_en  = 1'b0;
    len_push  = 1'b0;
    round_en  = 1'b0;
    fold_en   = 1'b0;
    out_valid = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (!empty) begin
          pop      = 1'b1;
          put_en   = head_cmd.has_byte;
          count_en = head_cmd.has_byte;
        end
      end
      ST_PAD: begin
        if (pad_first_r || bib_r != LEN_OFFSET) begin
          put_en  = 1'b1;
          put_val = pad_first_r ? PAD_MARK : 8'h00;
        end
      end
      ST_LEN:   len_push  = 1'b1;
      ST_ROUND: round_en  = 1'b1;
      ST_FOLD:  fold_en   = 1'b1;
      ST_OUT:   out_valid = 1'b1;
      default: ;
    endcase
  end

  assign out_done   = out_valid && out_ready && idx_r == LAST_INDEX;
  assign start_comp = (put_en && bib_r == BLOCK_LAST) || (len_push && len_sel_r);

  // Message length in bits, appended high word first.
  assign bit_len  = {msg_bytes_r, 3'b000};
  assign len_word = len_sel_r ? bit_len[31:0] : bit_len[63:32];

  // Schedule: the window holds the last 16 words, oldest at the front.
  assign w_new = {w_r[13][30:0] ^ w_r[8][30:0] ^ w_r[2][30:0] ^ w_r[0][30:0],
                  w_r[13][31] ^ w_r[8][31] ^ w_r[2][31] ^ w_r[0][31]};
  assign wt    = (rnd_r < 7'd16) ? w_r[0] : w_new;

  // Round function and constant by round group.
  always_comb begin
    if (rnd_r < 7'd20) begin
      f_val = (b_r & c_r) | (~b_r & d_r);
      k_val = K_0;
    end else if (rnd_r < 7'd40) begin
      f_val = b_r ^ c_r ^ d_r;
      k_val = K_1;
    end else if (rnd_r < 7'd60) begin
      f_val = (b_r & c_r) | (b_r & d_r) | (c_r & d_r);
      k_val = K_2;
    end else begin
      f_val = b_r ^ c_r ^ d_r;
      k_val = K_3;
    end
  end

  assign tmp = {a_r[26:0], a_r[31:27]} + f_val + e_r + k_val + wt;

  // Word entering the schedule window.
  assign shift_en = round_en || (put_en && bib_r[1:0] == 2'b11) || len_push;
  always_comb begin
    if (round_en) begin
      shift_in = wt;
    end else if (len_push) begin
      shift_in = len_word;
    end else begin
      shift_in = {acc_r, put_val};
    end
  end

  always_ff @(posedge clk) begin
    if (shift_en) begin
      for (int i = 0; i < 15; i++) begin
        w_r[i] <= w_r[i+1];
      end
      w_r[15] <= shift_in;
    end
    if (put_en) begin
      acc_r <= {acc_r[15:0], put_val};
    end
  end

  // Working variables.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_r <= '0;
      b_r <= '0;
      c_r <= '0;
      d_r <= '0;
      e_r <= '0;
    end else if (start_comp) begin
      a_r <= chain_r[0];
      b_r <= chain_r[1];
      c_r <= chain_r[2];
      d_r <= chain_r[3];
      e_r <= chain_r[4];
    end else if (round_en) begin
      a_r <= tmp;
      b_r <= a_r;
      c_r <= {b_r[1:0], b_r[31:2]};
      d_r <= c_r;
      e_r <= d_r;
    end
  end

  // Chaining state: folded after each block, restored after the digest.
  always_ff @(posedge clk) begin
    if (!rst_n || out_done) begin
      for (int i = 0; i < DIGEST_WORDS; i++) begin
        chain_r[i] <= H_INIT[i];
      end
    end else if (fold_en) begin
      chain_r[0] <= chain_r[0] + a_r;
      chain_r[1] <= chain_r[1] + b_r;
      chain_r[2] <= chain_r[2] + c_r;
      chain_r[3] <= chain_r[3] + d_r;
      chain_r[4] <= chain_r[4] + e_r;
    end
  end

  // Sequencer registers and counters.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      rnd_r       <= '0;
      bib_r       <= '0;
      msg_bytes_r <= '0;
      padding_r   <= 1'b0;
      pad_first_r <= 1'b0;
      len_sel_r   <= 1'b0;
      final_r     <= 1'b0;
      idx_r       <= '0;
    end else begin
      state_r <= state_nxt;
      if (start_comp) begin
        rnd_r <= '0;
      end else if (round_en) begin
        rnd_r <= (rnd_r == LAST_ROUND) ? '0 : rnd_r + 1'b1;
      end
      if (put_en) begin
        bib_r <= bib_r + 1'b1;
      end else if (len_push) begin
        bib_r <= bib_r + 6'd4;
      end
      if (count_en) begin
        msg_bytes_r <= msg_bytes_r + 1'b1;
      end else if (out_done) begin
        msg_bytes_r <= '0;
      end
      if (pop && head_cmd.end_of_message) begin
        padding_r   <= 1'b1;
        pad_first_r <= 1'b1;
      end else if (state_r == ST_PAD && put_en) begin
        pad_first_r <= 1'b0;
      end
      if (len_push) begin
        len_sel_r <= !len_sel_r;
        if (len_sel_r) begin
          final_r <= 1'b1;
        end
      end
      if (out_valid && out_ready) begin
        idx_r <= (idx_r == LAST_INDEX) ? '0 : idx_r + 1'b1;
      end
      if (out_done) begin
        padding_r <= 1'b0;
        final_r   <= 1'b0;
      end
    end
  end

  // Digest words are shown straight from the chaining registers.
  always_comb begin
    case (idx_r)
      3'd0:    out_digest_word = chain_r[0];
      3'd1:    out_digest_word = chain_r[1];
      3'd2:    out_digest_word = chain_r[2];
      3'd3:    out_digest_word = chain_r[3];
      default: out_digest_word = chain_r[4];
    endcase
  end

  assign out_word_index = idx_r;
  assign out_last_word  = (idx_r == LAST_INDEX);

endmodule

`default_nettype wire

FILE: test/tb_sha1_message_digest.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sha1_message_digest
// Self-checking bench for the byte-stream SHA-1 digest block.
// A short directed table covers known digests, field extremes and empty
// transactions. Random messages follow, with lengths that cross the padding
// boundaries. Known digests or an in-bench SHA-1 predictor check each result.
// ----------------------------------------------------------------------------

module tb_sha1_message_digest;
  import sha1md_pkg::*;

  localparam int CLK_HALF     = 4;
  localparam int RANDOM_ITEMS = 400;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int HOLD_AFTER   = 10;
  localparam int HOLD_CYCLES  = 600;
  localparam int DRAIN_CYCLES = 300;
  localparam int DIR_COUNT    = 14;

  localparam logic [159:0] SHA1_EMPTY = 160'hda39a3ee5e6b4b0d3255bfef95601890afd80709;
  localparam logic [159:0] SHA1_ABC   = 160'ha9993e364706816aba3e25717850c26c9cd0d89d;

  typedef struct packed {
    logic [7:0]   data_byte;
    logic         has_byte;
    logic         end_mark;
    logic         use_known;
    logic [159:0] known;
  } dir_row_t;

  typedef struct {
    logic [31:0] word;
    logic [2:0]  index;
    logic        last;
  } digest_slot_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  in_data_byte;
  logic        in_has_byte;
  logic        in_end_of_message;
  logic        out_valid;
  logic        out_ready;
  logic [31:0] out_digest_word;
  logic [2:0]  out_word_index;
  logic        out_last_word;

  // Predictor state: chaining words, schedule store, block fill and length.
  logic [31:0] sha1_chain [DIGEST_WORDS];
  logic [31:0] sha1_sched [16];
  logic [5:0]  fill_pos;
  logic [60:0] msg_len;

  digest_slot_t digest_words [$];
  dir_row_t     dir_rows [DIR_COUNT];
  logic         send_burst = 1'b0;
  int           mismatch_count = 0;
  int           cycle_count = 0;

  sha1_message_digest dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_data_byte      (in_data_byte),
    .in_has_byte       (in_has_byte),
    .in_end_of_message (in_end_of_message),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_digest_word   (out_digest_word),
    .out_word_index    (out_word_index),
    .out_last_word     (out_last_word)
  );

  always #CLK_HALF clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  function automatic logic [31:0] rol(input logic [31:0] x, input int n);
    return (x << n) | (x >> (32 - n));
  endfunction

  // One 80-round compression over the schedule store, folded into the chain.
  function automatic void compress_block();
    logic [31:0] a, b, c, d, e, f, k, t;
    int r;
    a = sha1_chain[0];
    b = sha1_chain[1];
    c = sha1_chain[2];
    d = sha1_chain[3];
    e = sha1_chain[4];
    for (r = 0; r < 80; r++) begin
      if (r >= 16) begin
        sha1_sched[r % 16] = rol(sha1_sched[(r + 13) % 16] ^ sha1_sched[(r + 8) % 16] ^
                                 sha1_sched[(r + 2) % 16] ^ sha1_sched[r % 16], 1);
      end
      if (r < 20) begin
        f = (b & c) | (~b & d);
        k = K_0;
      end else if (r < 40) begin
        f = b ^ c ^ d;
        k = K_1;
      end else if (r < 60) begin
        f = (b & c) | (b & d) | (c & d);
        k = K_2;
      end else begin
        f = b ^ c ^ d;
        k = K_3;
      end
      t = rol(a, 5) + f + e + k + sha1_sched[r % 16];
      e = d;
      d = c;
      c = rol(b, 30);
      b = a;
      a = t;
    end
    sha1_chain[0] = sha1_chain[0] + a;
    sha1_chain[1] = sha1_chain[1] + b;
    sha1_chain[2] = sha1_chain[2] + c;
    sha1_chain[3] = sha1_chain[3] + d;
    sha1_chain[4] = sha1_chain[4] + e;
  endfunction

  // Packs one byte big-endian into the block and compresses a full block.
  function automatic void absorb_byte(input logic [7:0] v);
    int w;
    int shift;
    w = int'(fill_pos[5:2]);
    shift = (3 - int'(fill_pos[1:0])) * 8;
    if (fill_pos[1:0] == 2'd0) sha1_sched[w] = '0;
    sha1_sched[w] = sha1_sched[w] | (32'(v) << shift);
    fill_pos = fill_pos + 6'd1;
    if (fill_pos == 6'd0) compress_block();
  endfunction

  // Applies one input transaction; returns 1 and the digest on an end mark.
  function automatic logic digest_step(input logic [7:0] data_byte, input logic has_byte,
                                       input logic end_mark, output logic [159:0] digest);
    logic [63:0] bit_len;
    int i;
    digest = '0;
    if (has_byte) begin
      absorb_byte(data_byte);
      msg_len = msg_len + 61'd1;
    end
    if (!end_mark) return 1'b0;
    bit_len = {msg_len, 3'b000};
    absorb_byte(PAD_MARK);
    while (fill_pos != LEN_OFFSET) absorb_byte(8'h00);
    sha1_sched[14] = bit_len[63:32];
    sha1_sched[15] = bit_len[31:0];
    compress_block();
    for (i = 0; i < DIGEST_WORDS; i++) begin
      digest[159 - 32 * i -: 32] = sha1_chain[i];
      sha1_chain[i] = H_INIT[i];
    end
    fill_pos = '0;
    msg_len = '0;
    return 1'b1;
  endfunction

  // Offers one input transaction after a random gap and predicts its results.
  task automatic send_item(input logic [7:0] data_byte, input logic has_byte,
                           input logic end_mark, input logic use_known,
                           input logic [159:0] known);
    int gap;
    int k;
    logic [159:0] digest;
    digest_slot_t slot;
    if ($urandom_range(0, 29) == 0) send_burst = !send_burst;
    gap = send_burst ? 0 : $urandom_range(0, 12);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data_byte <= data_byte;
    in_has_byte <= has_byte;
    in_end_of_message <= end_mark;
    @(posedge clk);
    while (in_ready !== 1'b1) @(posedge clk);
    if (digest_step(data_byte, has_byte, end_mark, digest)) begin
      if (use_known) digest = known;
      for (k = 0; k < DIGEST_WORDS; k++) begin
        slot.word = digest[159 - 32 * k -: 32];
        slot.index = 3'(k);
        slot.last = (3'(k) == LAST_INDEX);
        digest_words.push_back(slot);
      end
    end
  endtask

  // Receiver: random stalls, one long hold-off, and the check of each word.
  initial begin : drain
    int stall;
    int taken;
    logic burst;
    digest_slot_t want;
    taken = 0;
    burst = 1'b0;
    out_ready <= 1'b0;
    while (rst_n !== 1'b1) @(posedge clk);
    forever begin
      if ($urandom_range(0, 29) == 0) burst = !burst;
      stall = burst ? 0 : $urandom_range(0, 12);
      if (taken == HOLD_AFTER) stall = HOLD_CYCLES;
      if (stall != 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (out_valid !== 1'b1) @(posedge clk);
      taken++;
      if (digest_words.size() == 0) begin
        $error("unexpected output transaction: digest_word %h word_index %0d",
               out_digest_word, out_word_index);
        mismatch_count++;
      end else begin
        want = digest_words.pop_front();
        if (out_digest_word !== want.word) begin
          $error("digest_word: expected %h, got %h", want.word, out_digest_word);
          mismatch_count++;
        end
        if (out_word_index !== want.index) begin
          $error("word_index: expected %0d, got %0d", want.index, out_word_index);
          mismatch_count++;
        end
        if (out_last_word !== want.last) begin
          $error("last_word: expected %b, got %b", want.last, out_last_word);
          mismatch_count++;
        end
      end
    end
  end

  // Watchdog on the cycle counter.
  initial begin : watchdog
    wait (cycle_count >= CYCLE_LIMIT);
    $display("end of test: mismatches");
    $finish;
  end

  // Stimulus: reset, directed table, random messages, then drain.
  initial begin : stimulus
    int i;
    int len;
    int items;
    logic end_on_byte;
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_data_byte <= '0;
    in_has_byte <= 1'b0;
    in_end_of_message <= 1'b0;
    for (i = 0; i < DIGEST_WORDS; i++) sha1_chain[i] = H_INIT[i];
    for (i = 0; i < 16; i++) sha1_sched[i] = '0;
    fill_pos = '0;
    msg_len = '0;

    // Known vectors, field extremes, empty transactions and end marks.
    dir_rows = '{
      '{8'h5a, 1'b0, 1'b0, 1'b0, 160'h0},
      '{8'hff, 1'b0, 1'b1, 1'b1, SHA1_EMPTY},
      '{8'h61, 1'b1, 1'b0, 1'b0, 160'h0},
      '{8'hff, 1'b0, 1'b0, 1'b0, 160'h0},
      '{8'h62, 1'b1, 1'b0, 1'b0, 160'h0},
      '{8'h63, 1'b1, 1'b1, 1'b1, SHA1_ABC},
      '{8'h00, 1'b1, 1'b0, 1'b0, 160'h0},
      '{8'hff, 1'b1, 1'b0, 1'b0, 160'h0},
      '{8'h00, 1'b0, 1'b1, 1'b0, 160'h0},
      '{8'hff, 1'b1, 1'b1, 1'b0, 160'h0},
      '{8'h80, 1'b1, 1'b0, 1'b0, 160'h0},
      '{8'h7f, 1'b1, 1'b0, 1'b0, 160'h0},
      '{8'hff, 1'b0, 1'b1, 1'b0, 160'h0},
      '{8'h00, 1'b0, 1'b1, 1'b1, SHA1_EMPTY}
    };

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    for (i = 0; i < DIR_COUNT; i++) begin
      send_item(dir_rows[i].data_byte, dir_rows[i].has_byte, dir_rows[i].end_mark,
                dir_rows[i].use_known, dir_rows[i].known);
    end

    // Random messages; about one in five has a length near a block boundary.
    items = 0;
    while (items < RANDOM_ITEMS) begin
      if ($urandom_range(0, 4) == 0) begin
        case ($urandom_range(0, 7))
          0: len = 55;
          1: len = 56;
          2: len = 57;
          3: len = 63;
          4: len = 64;
          5: len = 65;
          6: len = 119;
          default: len = 120;
        endcase
      end else begin
        len = $urandom_range(0, 24);
      end
      end_on_byte = (len != 0) && ($urandom_range(0, 1) == 1);
      for (i = 0; i < len; i++) begin
        if ($urandom_range(0, 9) == 0) begin
          send_item(8'($urandom_range(0, 255)), 1'b0, 1'b0, 1'b0, 160'h0);
          items++;
        end
        send_item(8'($urandom_range(0, 255)), 1'b1, end_on_byte && (i == len - 1),
                  1'b0, 160'h0);
        items++;
      end
      if (!end_on_byte) begin
        send_item(8'($urandom_range(0, 255)), 1'b0, 1'b1, 1'b0, 160'h0);
        items++;
      end
    end
    in_valid <= 1'b0;

    // Let every expected word arrive, then watch for stray output.
    while (digest_words.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (digest_words.size() != 0) begin
      $error("%0d digest words never arrived", digest_words.size());
      mismatch_count++;
    end
    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/sha1md_pkg.sv
rtl/sha1md_queue.sv
rtl/sha1md_front.sv
rtl/sha1md_core.sv
rtl/sha1_message_digest.sv
test/tb_sha1_message_digest.sv
